/* rtl/eerg_pkg.sv */
// shared constants, codes and types for the encoder edge rate gated counter
`default_nettype none
package eerg_pkg;

    // field widths
    localparam int TIME_W = 32;
    localparam int POS_W  = 20;
    localparam int INTV_W = 24;
    localparam int STAT_W = 2;

    // interval history, depth must be a power of two (average is a shift)
    localparam int HIST_DEPTH = 16;
    localparam int HIST_BITS  = $clog2(HIST_DEPTH);
    localparam int SUM_W      = INTV_W + HIST_BITS;

    // stream word widths
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = STAT_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TARGET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LIMIT     = 2'd3;

    // reset values of the configuration registers
    localparam logic [POS_W-1:0]  POSITION_LIMIT_RST = 20'd4095;
    localparam logic [POS_W-1:0]  START_TARGET_RST   = 20'd0;
    localparam logic [INTV_W-1:0] GAP_LIMIT_RST      = 24'd250000;
    localparam logic [INTV_W-1:0] SLOW_LIMIT_RST     = 24'd60000;

    // edge status codes
    localparam logic [STAT_W-1:0] ST_COUNTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_GAP_LONG = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_SLOW = 2'd2;

    // verdict of the rate gate for the current edge
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              counted;
    } gate_res_t;

endpackage
`default_nettype wire

/* rtl/eerg_rate_gate.sv */
// interval measurement, history ring with running sum and rate gating
`default_nettype none
module eerg_rate_gate (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          fire,
    input  wire logic [eerg_pkg::TIME_W-1:0]   timestamp,
    input  wire logic [eerg_pkg::INTV_W-1:0]   gap_limit,
    input  wire logic [eerg_pkg::INTV_W-1:0]   slow_limit,
    output eerg_pkg::gate_res_t                res
);

    logic [eerg_pkg::TIME_W-1:0]    last_time_reg;
    logic [eerg_pkg::INTV_W-1:0]    ring_reg [eerg_pkg::HIST_DEPTH];
    logic [eerg_pkg::SUM_W-1:0]     sum_reg;
    logic [eerg_pkg::HIST_BITS-1:0] slot_reg;

    logic [eerg_pkg::TIME_W-1:0]    dt;
    logic [eerg_pkg::INTV_W-1:0]    dt_short;
    logic                           gap_long;
    logic [eerg_pkg::SUM_W-1:0]     sum_next;
    logic [eerg_pkg::INTV_W-1:0]    avg;
    logic [eerg_pkg::HIST_BITS-1:0] slot_next;

    // interval since previous edge, wraps with the timer
    assign dt       = timestamp - last_time_reg;
    assign dt_short = dt[eerg_pkg::INTV_W-1:0];
    assign gap_long = dt > {{(eerg_pkg::TIME_W-eerg_pkg::INTV_W){1'b0}}, gap_limit};

    // running sum: drop the oldest interval, add the new one
    assign sum_next = sum_reg
                    - {{eerg_pkg::HIST_BITS{1'b0}}, ring_reg[slot_reg]}
                    + {{eerg_pkg::HIST_BITS{1'b0}}, dt_short};
    assign avg      = sum_next[eerg_pkg::SUM_W-1:eerg_pkg::HIST_BITS];

    assign slot_next = (slot_reg == eerg_pkg::HIST_BITS'(eerg_pkg::HIST_DEPTH - 1))
                     ? '0 : slot_reg + 1'b1;

    // verdict
    always_comb begin
        if (gap_long) begin
            res.status  = eerg_pkg::ST_GAP_LONG;
            res.counted = 1'b0;
        end else if (avg > slow_limit) begin
            res.status  = eerg_pkg::ST_TOO_SLOW;
            res.counted = 1'b0;
        end else begin
            res.status  = eerg_pkg::ST_COUNTED;
            res.counted = 1'b1;
        end
    end

    // state update, the edge time is always taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            sum_reg       <= '0;
            slot_reg      <= '0;
            for (int i = 0; i < eerg_pkg::HIST_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
        end else if (fire) begin
            last_time_reg <= timestamp;
            if (!gap_long) begin
                ring_reg[slot_reg] <= dt_short;
                sum_reg            <= sum_next;
                slot_reg           <= slot_next;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/eerg_position.sv */
// target position counter with direction decode and clamp
`default_nettype none
module eerg_position (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        load,
    input  wire logic [eerg_pkg::POS_W-1:0]  load_value,
    input  wire logic                        fire,
    input  wire eerg_pkg::gate_res_t         gate,
    input  wire logic                        mode,
    input  wire logic                        other_level,
    input  wire logic [eerg_pkg::POS_W-1:0]  position_limit,
    output logic [eerg_pkg::POS_W-1:0]       position_next,
    output logic                             step_up
);

    logic [eerg_pkg::POS_W-1:0] count_reg;
    logic                       dir_up;
    logic [eerg_pkg::POS_W:0]   stepped;
    logic [eerg_pkg::POS_W-1:0] clamped;

    // channel a counts up on other low, channel b on other high
    assign dir_up = mode ? other_level : ~other_level;

    // step and clamp to 0..limit
    always_comb begin
        if (dir_up) begin
            stepped = {1'b0, count_reg} + 1'b1;
        end else if (count_reg == '0) begin
            stepped = '0;
        end else begin
            stepped = {1'b0, count_reg} - 1'b1;
        end
        if (stepped > {1'b0, position_limit}) begin
            clamped = position_limit;
        end else begin
            clamped = stepped[eerg_pkg::POS_W-1:0];
        end
    end

    assign position_next = gate.counted ? clamped : count_reg;
    assign step_up       = gate.counted & dir_up;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= eerg_pkg::START_TARGET_RST;
        end else if (load) begin
            count_reg <= load_value;
        end else if (fire) begin
            count_reg <= position_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/encoder_edge_rate_gated_counter_unit.sv */
// top level: stream ports, config registers, input and result registers
// path: a word waits in the input register, then its result is registered onto m_tvalid
// throughput: one edge word per cycle while m_tready does not stall, set by the update loop
//   through the interval ring, running sum and position counter
// reset: synchronous active-low aresetn clears the ring, sum, edge time and
//   handshake state and loads config defaults; target loads START_TARGET_RST
`default_nettype none
module encoder_edge_rate_gated_counter_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input edge words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [eerg_pkg::S_DATA_W-1:0]     s_tdata,  // other_level, timestamp_us
    input  wire logic [eerg_pkg::S_USER_W-1:0]     s_tuser,  // mode
    // result words
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [eerg_pkg::M_DATA_W-1:0]          m_tdata,  // target_position, step_up
    output logic [eerg_pkg::M_USER_W-1:0]          m_tuser,  // edge_status
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [eerg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [eerg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // config registers
    logic [eerg_pkg::POS_W-1:0]  pos_limit_reg;
    logic [eerg_pkg::INTV_W-1:0] gap_limit_reg;
    logic [eerg_pkg::INTV_W-1:0] slow_limit_reg;
    logic                        cfg_wr;
    logic                        load_target;

    // input register
    logic                        in_valid_reg;
    logic                        mode_reg;
    logic                        other_reg;
    logic [eerg_pkg::TIME_W-1:0] time_reg;

    // result register
    logic                        out_valid_reg;
    logic [eerg_pkg::POS_W-1:0]  out_pos_reg;
    logic [eerg_pkg::STAT_W-1:0] out_stat_reg;
    logic                        out_up_reg;

    logic                        fire;
    eerg_pkg::gate_res_t         gate;
    logic [eerg_pkg::POS_W-1:0]  pos_next;
    logic                        step_up;

    assign cfg_ready   = 1'b1;
    assign cfg_wr      = cfg_valid & cfg_ready;
    assign load_target = cfg_wr & (cfg_index == eerg_pkg::CFG_START_TARGET);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_limit_reg  <= eerg_pkg::POSITION_LIMIT_RST;
            gap_limit_reg  <= eerg_pkg::GAP_LIMIT_RST;
            slow_limit_reg <= eerg_pkg::SLOW_LIMIT_RST;
        end else if (cfg_wr) begin
            case (cfg_index)
                eerg_pkg::CFG_POSITION_LIMIT: pos_limit_reg <= cfg_data[eerg_pkg::POS_W-1:0];
                eerg_pkg::CFG_START_TARGET: begin
                end
                eerg_pkg::CFG_GAP_LIMIT:      gap_limit_reg  <= cfg_data;
                eerg_pkg::CFG_SLOW_LIMIT:     slow_limit_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // process the held word when the result register is free
    assign fire     = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready & s_tvalid) begin
            mode_reg  <= s_tuser[0];
            other_reg <= s_tdata[0];
            time_reg  <= s_tdata[eerg_pkg::TIME_W:1];
        end
    end

    eerg_rate_gate u_gate (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .timestamp  (time_reg),
        .gap_limit  (gap_limit_reg),
        .slow_limit (slow_limit_reg),
        .res        (gate)
    );

    eerg_position u_pos (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (load_target),
        .load_value     (cfg_data[eerg_pkg::POS_W-1:0]),
        .fire           (fire),
        .gate           (gate),
        .mode           (mode_reg),
        .other_level    (other_reg),
        .position_limit (pos_limit_reg),
        .position_next  (pos_next),
        .step_up        (step_up)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_pos_reg  <= pos_next;
            out_stat_reg <= gate.status;
            out_up_reg   <= step_up;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(eerg_pkg::M_DATA_W-eerg_pkg::POS_W-1){1'b0}}, out_up_reg, out_pos_reg};
    assign m_tuser  = out_stat_reg;

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the rate gated encoder edge counter, stream driven
module testbench;
    import eerg_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_EDGES  = 104;
    localparam int MAX_IDLE     = 12;

    // one expected result word
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [STAT_W-1:0] status;
        logic              step_up;
    } edge_result_t;

    // rate gate predictor and the queue of results still owed by the block
    class edge_scoreboard;
        logic [POS_W-1:0]     pos_limit;
        logic [POS_W-1:0]     start_tgt;
        logic [INTV_W-1:0]    gap_lim;
        logic [INTV_W-1:0]    slow_lim;
        logic [TIME_W-1:0]    last_ts;
        logic [INTV_W-1:0]    ring [HIST_DEPTH];
        logic [SUM_W-1:0]     sum;
        logic [HIST_BITS-1:0] slot;
        logic [POS_W-1:0]     target;
        edge_result_t         expected_q[$];
        int                   errors;

        function new();
            errors    = 0;
            pos_limit = POSITION_LIMIT_RST;
            start_tgt = START_TARGET_RST;
            gap_lim   = GAP_LIMIT_RST;
            slow_lim  = SLOW_LIMIT_RST;
            last_ts   = '0;
            sum       = '0;
            slot      = '0;
            target    = START_TARGET_RST;
            foreach (ring[i]) ring[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_POSITION_LIMIT: pos_limit = value[POS_W-1:0];
                CFG_START_TARGET: begin
                    start_tgt = value[POS_W-1:0];
                    target    = start_tgt;
                end
                CFG_GAP_LIMIT:  gap_lim  = value[INTV_W-1:0];
                CFG_SLOW_LIMIT: slow_lim = value[INTV_W-1:0];
                default: ;
            endcase
        endfunction

        // accepted edge word: gate on gap, then on the ring average, then step
        function void note_edge(logic chan_b, logic other, logic [TIME_W-1:0] ts);
            logic [TIME_W-1:0] interval;
            logic [SUM_W-1:0]  avg;
            logic [POS_W:0]    nxt;
            edge_result_t      res;
            interval    = ts - last_ts;
            last_ts     = ts;
            res.step_up = 1'b0;
            if (interval > gap_lim) begin
                res.status = ST_GAP_LONG;
            end else begin
                sum        = sum - ring[slot] + interval[INTV_W-1:0];
                ring[slot] = interval[INTV_W-1:0];
                slot       = slot + 1'b1;
                avg        = sum >> HIST_BITS;
                if (avg > slow_lim) begin
                    res.status = ST_TOO_SLOW;
                end else begin
                    res.status  = ST_COUNTED;
                    res.step_up = chan_b ? other : ~other;
                    if (res.step_up)
                        nxt = {1'b0, target} + 1'b1;
                    else if (target == '0)
                        nxt = '0;
                    else
                        nxt = {1'b0, target} - 1'b1;
                    if (nxt > pos_limit)
                        nxt = {1'b0, pos_limit};
                    target = nxt[POS_W-1:0];
                end
            end
            res.position = target;
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [POS_W-1:0] pos, logic [STAT_W-1:0] status, logic up);
            edge_result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected word pos=%0d status=%0d up=%0d", pos, status, up));
                return;
            end
            want = expected_q.pop_front();
            if (pos !== want.position)
                report($sformatf("target_position %0d, want %0d", pos, want.position));
            if (status !== want.status)
                report($sformatf("edge_status %0d, want %0d", status, want.status));
            if (up !== want.step_up)
                report($sformatf("step_up %0d, want %0d", up, want.step_up));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [S_USER_W-1:0]   s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    edge_scoreboard        sb;
    logic [TIME_W-1:0]     ts_now    = '0;
    logic [INTV_W-1:0]     cur_gap   = GAP_LIMIT_RST;
    logic [INTV_W-1:0]     cur_slow  = SLOW_LIMIT_RST;
    bit                    steady    = 1'b0;
    bit                    hold_req  = 1'b0;
    int                    cycles    = 0;

    encoder_edge_rate_gated_counter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // offer one edge word after a random gap (none when steady), return at the accepting edge
    task automatic send_edge(input logic chan_b, input logic other, input logic [TIME_W-1:0] ts);
        int   idle;
        logic hit;
        idle = steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= chan_b;
        s_tdata  <= {{(S_DATA_W-TIME_W-1){1'b0}}, ts, other};
        do begin
            @(negedge aclk);
            hit = s_tready;
            @(posedge aclk);
        end while (!hit);
        sb.note_edge(chan_b, other, ts);
    endtask

    task automatic send_rel(input logic chan_b, input logic other, input logic [TIME_W-1:0] dt);
        ts_now = ts_now + dt;
        send_edge(chan_b, other, ts_now);
    endtask

    // wait until every result is back, block then idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // write all four registers, only called while idle
    task automatic configure(input logic [CFG_DATA_W-1:0] pos_v, input logic [CFG_DATA_W-1:0] start_v,
                             input logic [CFG_DATA_W-1:0] gap_v, input logic [CFG_DATA_W-1:0] slow_v);
        logic [CFG_IDX_W-1:0]  idx [4] = '{CFG_POSITION_LIMIT, CFG_START_TARGET,
                                           CFG_GAP_LIMIT, CFG_SLOW_LIMIT};
        logic [CFG_DATA_W-1:0] vals [4];
        logic                  hit;
        vals = '{pos_v, start_v, gap_v, slow_v};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do begin
                @(negedge aclk);
                hit = cfg_ready;
                @(posedge aclk);
            end while (!hit);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
        cur_gap  = gap_v;
        cur_slow = slow_v;
    endtask

    // interval mix: mostly fast edges, plus limit edges, long gaps and wraps
    function automatic logic [TIME_W-1:0] next_interval();
        int unsigned       r;
        logic [TIME_W-1:0] cap;
        r   = $urandom_range(0, 99);
        cap = (cur_slow < cur_gap) ? cur_slow : cur_gap;
        if (r < 65) return $urandom_range(0, cap);
        if (r < 72) return cur_gap;
        if (r < 77) return cur_gap + 1;
        if (r < 82) return cur_slow + $urandom_range(0, 2) - 1;
        if (r < 88) return $urandom;
        if (r < 93) return '0;
        return $urandom_range(0, cur_gap);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_position();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return {4'h0, {POS_W{1'b1}}};
        if (r < 6) return $urandom_range(1, 64);
        return $urandom_range(0, (1 << POS_W) - 1);
    endfunction

    // result monitor, sampled mid-cycle
    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata[POS_W-1:0], m_tuser, m_tdata[POS_W]);
        end
    end

    // result receiver with random stalls and one long hold-off on request
    initial begin : receiver
        int   stall;
        logic hit;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall    = hold_req ? HOLD_CYCLES : (steady ? 0 : $urandom_range(0, MAX_IDLE));
            hold_req = 1'b0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                hit = m_tvalid;
                @(posedge aclk);
            end while (!hit);
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("** encoder_edge_rate_gated_counter_unit: FAILED **");
        $finish;
    end

    // main sequence
    initial begin
        logic [CFG_DATA_W-1:0] pos_v;
        logic [CFG_DATA_W-1:0] start_v;
        logic [CFG_DATA_W-1:0] gap_v;
        logic [CFG_DATA_W-1:0] slow_v;
        int unsigned           r;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: all directions, down at zero, gap boundary, wrap
        send_rel(1'b0, 1'b1, 32'd5);
        send_rel(1'b0, 1'b0, 32'd100);
        send_rel(1'b1, 1'b1, 32'd100);
        send_rel(1'b1, 1'b0, 32'd100);
        send_rel(1'b0, 1'b1, 32'd0);
        send_rel(1'b0, 1'b0, 32'd250000);
        send_rel(1'b1, 1'b1, 32'd250001);
        ts_now = 32'hFFFF_FFF0;
        send_edge(1'b1, 1'b1, ts_now);
        send_rel(1'b0, 1'b0, 32'h20);
        repeat (5) send_rel(1'b0, 1'b0, 32'd240000);
        drain();

        // count above the limit, widest limits, upper data bits dropped
        configure(24'hF00003, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_rel(1'b1, 1'b1, 32'h0100_0000);
        send_rel(1'b0, 1'b1, 32'd7);
        send_rel(1'b0, 1'b0, 32'd1);
        send_rel(1'b0, 1'b0, 32'h00FF_FFFF);
        drain();

        // all limits at zero
        configure('0, '0, '0, '0);
        send_rel(1'b0, 1'b0, 32'd0);
        send_rel(1'b1, 1'b0, 32'd1);
        send_rel(1'b1, 1'b1, 32'd0);
        send_rel(1'b0, 1'b1, 32'd0);
        drain();

        // random phases, each under its own settings
        for (int p = 0; p < PHASES; p++) begin
            steady = (p == 2) || (p == 5);
            pos_v  = pick_position();
            r      = $urandom_range(0, 3);
            start_v = (r == 0) ? 24'($urandom_range(0, (1 << POS_W) - 1))
                               : 24'($urandom_range(0, pos_v));
            start_v[CFG_DATA_W-1:POS_W] = $urandom_range(0, 15);
            pos_v[CFG_DATA_W-1:POS_W]   = $urandom_range(0, 15);
            r = $urandom_range(0, 9);
            gap_v = (r == 0) ? 24'd0 : (r == 1) ? {CFG_DATA_W{1'b1}}
                                     : 24'($urandom_range(100, 300000));
            r = $urandom_range(0, 9);
            slow_v = (r == 0) ? 24'd0 : (r == 1) ? {CFG_DATA_W{1'b1}}
                                      : 24'($urandom_range(0, gap_v));
            configure(pos_v, start_v, gap_v, slow_v);
            if (p == 3)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_EDGES; n++) begin
                if ($urandom_range(0, 19) == 0)
                    ts_now = $urandom;
                else
                    ts_now = ts_now + next_interval();
                send_edge($urandom_range(0, 1), $urandom_range(0, 1), ts_now);
            end
            drain();
        end

        repeat (5) @(posedge aclk);
        if (sb.errors == 0)
            $display("** encoder_edge_rate_gated_counter_unit: PASSED **");
        else
            $display("** encoder_edge_rate_gated_counter_unit: FAILED **");
        $finish;
    end

endmodule
